/* design/hts_pkg.sv */
// Shared types and constants for the HTML tag stripper.
// Byte classes, the queued word format and the default queue depth.
// No dependencies.
package hts_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One code per byte kind the parser ever tells apart; letters fold case.
  typedef enum logic [3:0] {
    CL_LT,
    CL_GT,
    CL_BANG,
    CL_DASH,
    CL_SLASH,
    CL_S,
    CL_T,
    CL_Y,
    CL_L,
    CL_E,
    CL_QUAL,
    CL_OTHER
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    byte_cls_t  cls;
  } item_t;

endpackage

/* design/hts_front.sv */
// Front end: input register and byte classifier.
// Depends on hts_pkg; feeds the word queue.
module hts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          q_push,
  output hts_pkg::item_t q_data,
  input  logic          q_full
);
  import hts_pkg::*;

  logic       valid_r;
  item_t      item_r;
  logic       advance;
  logic [7:0] lc;
  byte_cls_t  cls;

  always_comb begin
    lc = in_byte;
    if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
      lc = in_byte + 8'h20;
    end
    priority if (in_byte == CH_LT) begin
      cls = CL_LT;
    end else if (in_byte == CH_GT) begin
      cls = CL_GT;
    end else if (in_byte == CH_BANG) begin
      cls = CL_BANG;
    end else if (in_byte == CH_DASH) begin
      cls = CL_DASH;
    end else if (in_byte == CH_SLASH) begin
      cls = CL_SLASH;
    end else if (lc == 8'h73) begin
      cls = CL_S;
    end else if (lc == 8'h74) begin
      cls = CL_T;
    end else if (lc == 8'h79) begin
      cls = CL_Y;
    end else if (lc == 8'h6C) begin
      cls = CL_L;
    end else if (lc == 8'h65) begin
      cls = CL_E;
    end else if (in_byte <= CH_SPACE || in_byte[7]) begin
      cls = CL_QUAL;
    end else begin
      cls = CL_OTHER;
    end
  end

  assign advance = !valid_r || !q_full;
  assign full    = valid_r && q_full;
  assign q_push  = valid_r && !q_full;
  assign q_data  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      item_r <= '{data: in_byte, last: in_last, cls: cls};
    end
  end

endmodule

/* design/hts_fifo.sv */
// Short word queue between front and back ends.
// Depends on hts_pkg for the word format.
module hts_fifo #(
  parameter int unsigned DEPTH = hts_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  hts_pkg::item_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output hts_pkg::item_t rd_data,
  output logic           empty
);
  import hts_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/hts_back.sv */
// Back end: markup parser state machine and result register.
// Depends on hts_pkg; drains the word queue.
module hts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hts_pkg::item_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_keep,
  output logic           out_last
);
  import hts_pkg::*;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_LT,
    MODE_BANG,
    MODE_STYLEOPEN,
    MODE_TAG,
    MODE_COMMENT,
    MODE_STYLE
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [2:0] prog_r, prog_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       keep_r;
  logic       last_r;
  logic       keep_nxt;
  logic       take;
  byte_cls_t  cls;

  // Expected class at each position of the closing "</style>".
  function automatic byte_cls_t close_cls(input logic [2:0] p);
    byte_cls_t r;
    unique case (p)
      3'd0:    r = CL_LT;
      3'd1:    r = CL_SLASH;
      3'd2:    r = CL_S;
      3'd3:    r = CL_T;
      3'd4:    r = CL_Y;
      3'd5:    r = CL_L;
      3'd6:    r = CL_E;
      default: r = CL_GT;
    endcase
    return r;
  endfunction

  assign cls   = q_data.cls;
  assign take  = !q_empty && (!valid_r || pop);
  assign q_pop = take;
  assign empty = !valid_r;
  assign out_byte = byte_r;
  assign out_keep = keep_r;
  assign out_last = last_r;

  always_comb begin
    mode_nxt = mode_r;
    prog_nxt = prog_r;
    keep_nxt = 1'b0;
    unique case (mode_r)
      MODE_TEXT: begin
        if (cls == CL_LT) begin
          mode_nxt = MODE_LT;
          prog_nxt = 3'd0;
        end else begin
          keep_nxt = 1'b1;
        end
      end
      MODE_LT: begin
        prog_nxt = 3'd0;
        priority if (cls == CL_BANG) begin
          mode_nxt = MODE_BANG;
          prog_nxt = 3'd1;
        end else if (cls == CL_S) begin
          mode_nxt = MODE_STYLEOPEN;
          prog_nxt = 3'd1;
        end else if (cls == CL_GT) begin
          mode_nxt = MODE_TEXT;
        end else begin
          mode_nxt = MODE_TAG;
        end
      end
      MODE_BANG: begin
        prog_nxt = 3'd0;
        priority if (cls == CL_DASH) begin
          if (prog_r >= 3'd2) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            prog_nxt = prog_r + 3'd1;
          end
        end else if (cls == CL_GT) begin
          mode_nxt = MODE_TEXT;
        end else begin
          mode_nxt = MODE_TAG;
        end
      end
      MODE_STYLEOPEN: begin
        prog_nxt = 3'd0;
        if (prog_r < 3'd5) begin
          // opener letters sit two places on in the closer pattern
          priority if (cls == close_cls(prog_r + 3'd2)) begin
            prog_nxt = prog_r + 3'd1;
          end else if (cls == CL_GT) begin
            mode_nxt = MODE_TEXT;
          end else begin
            mode_nxt = MODE_TAG;
          end
        end else if (cls == CL_QUAL || cls == CL_GT || cls == CL_SLASH) begin
          mode_nxt = MODE_STYLE;
        end else begin
          mode_nxt = MODE_TAG;
        end
      end
      MODE_TAG: begin
        if (cls == CL_GT) begin
          mode_nxt = MODE_TEXT;
          prog_nxt = 3'd0;
        end
      end
      MODE_COMMENT: begin
        priority if (cls == CL_DASH) begin
          prog_nxt = (prog_r >= 3'd2) ? 3'd2 : prog_r + 3'd1;
        end else if (cls == CL_GT && prog_r >= 3'd2) begin
          mode_nxt = MODE_TEXT;
          prog_nxt = 3'd0;
        end else begin
          prog_nxt = 3'd0;
        end
      end
      MODE_STYLE: begin
        // restart on '<' so overlapping closers are found
        priority if (cls == close_cls(prog_r)) begin
          if (prog_r == 3'd7) begin
            mode_nxt = MODE_TEXT;
            prog_nxt = 3'd0;
          end else begin
            prog_nxt = prog_r + 3'd1;
          end
        end else if (cls == CL_LT) begin
          prog_nxt = 3'd1;
        end else begin
          prog_nxt = 3'd0;
        end
      end
      default: begin
        prog_nxt = 3'd0;
        if (cls == CL_LT) begin
          mode_nxt = MODE_LT;
        end else begin
          mode_nxt = MODE_TEXT;
          keep_nxt = 1'b1;
        end
      end
    endcase
    if (q_data.last) begin
      mode_nxt = MODE_TEXT;
      prog_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      prog_r  <= 3'd0;
      valid_r <= 1'b0;
      byte_r  <= 8'h00;
      keep_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      if (take) begin
        mode_r <= mode_nxt;
        prog_r <= prog_nxt;
        byte_r <= keep_nxt ? q_data.data : 8'h00;
        keep_r <= keep_nxt;
        last_r <= q_data.last;
      end
      if (take) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

/* design/html_tag_stripper.sv */
// HTML tag stripper top level: front end, word queue and back end.
// Depends on hts_pkg, hts_front, hts_fifo and hts_back.
//
//   channel  handshake     ports
//   input    push / full   in_byte, in_last
//   result   pop / empty   out_byte, out_keep, out_last
//
// One byte a cycle sustained while the result side pops; each byte passes
// through the input register, the queue and the parser register on its way
// to the result ports. The parser state update is the single per-byte loop.
// Synchronous active-low reset empties every stage and returns to text mode.
// A stalled result side fills the queue; full then rises and holds the input.
module html_tag_stripper #(
  parameter int unsigned FIFO_DEPTH = hts_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_keep,
  output logic       out_last
);
  import hts_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_wr;
  item_t q_rd;

  hts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_push  (q_push),
    .q_data  (q_wr),
    .q_full  (q_full)
  );

  hts_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  hts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_keep (out_keep),
    .out_last (out_last)
  );

endmodule
